// ----- rtl/bpfm_pkg.sv -----
`default_nettype none
package bpfm_pkg;

   // pattern register geometry (fixed by the register map)
   localparam int PAT_BYTES_MAX = 8;
   localparam int PAT_WIDTH     = 64;
   localparam int LEN_WIDTH     = 4;
   localparam int START_WIDTH   = 32;
   localparam int RESULT_WIDTH  = 32;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_BYTES  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEARCH_START   = 2'd2;

   typedef logic [7:0] byte_type;

   // control broadcast from the top level to every window cell
   typedef struct packed {
      logic                 shift;
      logic [LEN_WIDTH-1:0] pat_len;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ----- rtl/bpfm_cell.sv -----
`default_nettype none
module bpfm_cell import bpfm_pkg::*; #(
   parameter int INDEX = 0
) (
   input  wire logic                 clock,
   input  wire cell_ctrl_type        ctrl,
   input  wire logic [PAT_WIDTH-1:0] pattern_bytes,
   input  wire byte_type             shift_in,
   output byte_type                  byte_out,
   output logic                      hit
);

   byte_type                 byte_ff;
   byte_type                 byte_in;
   logic [LEN_WIDTH-1:0]     sel;
   logic [5:0]               bit_base;
   logic                     in_use;

   // pattern byte that lines up with this window slot: len-1-INDEX
   assign sel      = ctrl.pat_len - LEN_WIDTH'(INDEX) - LEN_WIDTH'(1);
   assign bit_base = {sel[2:0], 3'b000};
   assign in_use   = ctrl.pat_len > LEN_WIDTH'(INDEX);

   // compare against the value this slot takes on the current word
   assign hit = !in_use || (shift_in == pattern_bytes[bit_base +: 8]);

   // window shift toward the older end
   assign byte_in = ctrl.shift ? shift_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign byte_out = byte_ff;

endmodule
`default_nettype wire

// ----- rtl/byte_pattern_first_match_core.sv -----
`default_nettype none
// Streaming exact-substring search, first match only.
// req channel: one buffer byte per word, req_tlast on the final byte.
// rsp channel: at most one word per buffer. rsp_tuser = 1 with the start
//   offset of the first match at or after search_start, sent on the byte
//   that completes the match; rsp_tuser = 0 with offset 0 on the final byte
//   when nothing matched. Bytes after a match are absorbed without output.
// csr channel: always ready; index 0 pattern bytes (first byte in [7:0]),
//   1 pattern length (1..PATTERN_MAX, other values never match),
//   2 search start offset. Write only while no buffer is in flight.
// Throughput: one byte per clock when not stalled. A row of PATTERN_MAX
//   window cells shifts one slot per accepted byte and each compares its slot
//   in parallel; the hit AND, start-offset subtract and compare finish in the
//   same cycle, and the result is registered on the byte that causes it.
// Stall: the result register holds while rsp_tready is low; a new byte is
//   accepted as long as the result register is empty or being drained.
// Reset: synchronous, active high. Clears the byte count, the match flag and
//   the output valid, and returns the registers to pattern 0, length 1,
//   start 0. The byte count saturates at 2^OFFSET_BITS-1.
module byte_pattern_first_match_core import bpfm_pkg::*; #(
   parameter int PATTERN_MAX = 8,
   parameter int OFFSET_BITS = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // csr write channel
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [PAT_WIDTH-1:0]       csr_data,
   // byte stream in
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [7:0]                 req_tdata,   // [7:0] byte_value
   input  wire logic                       req_tlast,   // last_byte
   // result out
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [RESULT_WIDTH-1:0]         rsp_tdata,   // [31:0] match_offset
   output logic                            rsp_tuser    // [0] found
);

   localparam int WIDE = ((OFFSET_BITS > START_WIDTH) ? OFFSET_BITS : START_WIDTH) + 1;

   // configuration registers
   logic [PAT_WIDTH-1:0]   pat_ff;
   logic [LEN_WIDTH-1:0]   len_ff;
   logic [START_WIDTH-1:0] start_ff;

   // buffer state
   logic [OFFSET_BITS-1:0] cnt_ff, cnt_in;
   logic                   reported_ff, reported_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    found_ff, found_in;
   logic [RESULT_WIDTH-1:0] offset_ff, offset_in;

   logic                    accept;
   logic                    len_ok, not_sat, enough, after_start, all_hit, hit_now, load;
   logic [WIDE-1:0]         pos_plus1, start_pos;
   logic [PATTERN_MAX-1:0]  hits;
   byte_type                chain [PATTERN_MAX+1];
   cell_ctrl_type           ctrl;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff   <= '0;
         len_ff   <= LEN_WIDTH'(1);
         start_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PATTERN_BYTES:  pat_ff   <= csr_data;
            CSR_PATTERN_LENGTH: len_ff   <= csr_data[LEN_WIDTH-1:0];
            CSR_SEARCH_START:   start_ff <= csr_data[START_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // window cells, slot 0 holds the newest byte
   assign ctrl.shift   = accept;
   assign ctrl.pat_len = len_ff;
   assign chain[0]     = req_tdata;

   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      bpfm_cell #(.INDEX(k)) u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .pattern_bytes (pat_ff),
         .shift_in      (chain[k]),
         .byte_out      (chain[k+1]),
         .hit           (hits[k])
      );
   end

   // match qualification on the current byte
   assign len_ok      = (len_ff != '0) && (len_ff <= LEN_WIDTH'(PATTERN_MAX));
   assign not_sat     = !(&cnt_ff);
   assign pos_plus1   = WIDE'(cnt_ff) + WIDE'(1);
   assign start_pos   = pos_plus1 - WIDE'(len_ff);
   assign enough      = pos_plus1 >= WIDE'(len_ff);
   assign after_start = start_pos >= WIDE'(start_ff);
   assign all_hit     = &hits;
   assign hit_now     = !reported_ff && len_ok && not_sat && enough && after_start && all_hit;
   assign load        = accept && (hit_now || (req_tlast && !reported_ff));

   // count, match flag and result next state
   always_comb begin
      cnt_in       = cnt_ff;
      reported_in  = reported_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      found_in     = found_ff;
      offset_in    = offset_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         found_in     = hit_now;
         offset_in    = hit_now ? start_pos[RESULT_WIDTH-1:0] : '0;
      end
      if (accept) begin
         if (req_tlast) begin
            cnt_in      = '0;
            reported_in = 1'b0;
         end else begin
            reported_in = reported_ff || hit_now;
            if (not_sat) begin
               cnt_in = cnt_ff + OFFSET_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff  <= found_in;
      offset_ff <= offset_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = offset_ff;
   assign rsp_tuser  = found_ff;

   // buffer state is clean after the final byte
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> cnt_ff == '0 && !reported_ff)
      else $error("buffer state not cleared after final byte");

   // a not-found result only comes from the final byte
   a_notfound_on_last: assert property (@(posedge clock) disable iff (reset)
      load && !hit_now |-> req_tlast)
      else $error("not-found result before buffer end");

   // a match is remembered for the rest of the buffer
   a_match_sticky: assert property (@(posedge clock) disable iff (reset)
      accept && hit_now && !req_tlast |=> reported_ff)
      else $error("match flag not set after match");

   // a held result blocks new bytes
   a_stall_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("byte accepted while result register full");

endmodule
`default_nettype wire

// ----- bench/tb_byte_pattern_first_match_core.sv -----
module tb_byte_pattern_first_match_core;
   import bpfm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int OFFSET_BITS = 32;
   localparam longint unsigned COUNT_MAX = (64'd1 << OFFSET_BITS) - 64'd1;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_BYTES = 600;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [PAT_WIDTH-1:0]       csr_data = '0;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata = '0;    // [7:0] byte_value
   logic                       req_tlast = 1'b0;  // last_byte
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RESULT_WIDTH-1:0]    rsp_tdata;         // [31:0] match_offset
   logic                       rsp_tuser;         // [0] found

   typedef struct {
      logic                    found;
      logic [RESULT_WIDTH-1:0] offset;
   } search_report_type;

   // first-match predictor with its own copy of the registers and window
   class first_match_predictor;
      logic [PAT_WIDTH-1:0]   pattern;
      logic [LEN_WIDTH-1:0]   pat_len;
      logic [START_WIDTH-1:0] search_from;
      logic [7:0]             window[PAT_BYTES_MAX];
      longint unsigned        bytes_seen;
      bit                     reported;
      search_report_type      pending_reports[$];
      int errors, buffers, hits, misses;

      function new();
         pattern = '0;
         pat_len = 1;
         search_from = '0;
         clear_buffer();
         errors = 0;
         buffers = 0;
         hits = 0;
         misses = 0;
      endfunction

      function void clear_buffer();
         foreach (window[i]) window[i] = 8'h00;
         bytes_seen = 0;
         reported = 1'b0;
      endfunction

      function void set_reg(logic [CSR_INDEX_WIDTH-1:0] index, logic [PAT_WIDTH-1:0] value);
         case (index)
            CSR_PATTERN_BYTES:  pattern = value;
            CSR_PATTERN_LENGTH: pat_len = value[LEN_WIDTH-1:0];
            CSR_SEARCH_START:   search_from = value[START_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_reports.size();
      endfunction

      // one accepted byte: shift the window, look for the first match
      function void note_byte(logic [7:0] value, logic last_mark);
         longint unsigned   pos;
         longint unsigned   first;
         bit                hit;
         search_report_type rep;
         pos = bytes_seen;
         hit = 1'b0;
         for (int i = PAT_BYTES_MAX - 1; i > 0; i--) window[i] = window[i-1];
         window[0] = value;
         if (!reported && pat_len >= 1 && pat_len <= PAT_BYTES_MAX &&
             pos < COUNT_MAX && pos + 1 >= pat_len) begin
            first = pos + 1 - pat_len;
            if (first >= search_from) begin
               hit = 1'b1;
               for (int i = 0; i < pat_len; i++) begin
                  if (window[pat_len - 1 - i] != pattern[8*i +: 8]) hit = 1'b0;
               end
            end
         end
         if (hit) begin
            reported = 1'b1;
            rep.found = 1'b1;
            rep.offset = first[RESULT_WIDTH-1:0];
            pending_reports.push_back(rep);
            hits++;
         end
         if (last_mark) begin
            if (!reported) begin
               rep.found = 1'b0;
               rep.offset = '0;
               pending_reports.push_back(rep);
               misses++;
            end
            buffers++;
            clear_buffer();
         end else if (bytes_seen < COUNT_MAX) begin
            bytes_seen++;
         end
      endfunction

      // one accepted result word against the oldest expectation
      function void check_report(logic found, logic [RESULT_WIDTH-1:0] offset);
         search_report_type rep;
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected result word found=%0d offset=%0d",
                     $time, found, offset);
            errors++;
            return;
         end
         rep = pending_reports.pop_front();
         if (found !== rep.found) begin
            $display("%0t: found mismatch, expected %0d actual %0d",
                     $time, rep.found, found);
            errors++;
         end
         if (offset !== rep.offset) begin
            $display("%0t: match_offset mismatch, expected %0d actual %0d",
                     $time, rep.offset, offset);
            errors++;
         end
      endfunction
   endclass

   first_match_predictor predictor = new();

   int byte_count = 0;
   int setting_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_left = 0;
   int cycles = 0;

   byte_pattern_first_match_core #(
      .PATTERN_MAX(PAT_BYTES_MAX),
      .OFFSET_BITS(OFFSET_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, predictor.pending());
         $display("** byte_pattern_first_match_core: FAILED **");
         $finish;
      end
   end

   // all handshakes are observed here, results checked before new bytes noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) predictor.check_report(rsp_tuser, rsp_tdata);
         if (csr_valid && csr_ready) predictor.set_reg(csr_index, csr_data);
         if (req_tvalid && req_tready) predictor.note_byte(req_tdata, req_tlast);
      end
   end

   // random result side back-pressure while recv_idle_pct is nonzero
   always @(negedge clock) begin
      if (reset || recv_idle_pct == 0) begin
         stall_left = 0;
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
         stall_left = $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // one word on the byte stream, with an optional gap ahead of it
   task automatic push_byte(input logic [7:0] value, input logic last_mark);
      int gap;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tlast <= last_mark;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      byte_count++;
   endtask

   // csr_valid stays high across back-to-back writes; caller lowers it
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [PAT_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic configure(input logic [PAT_WIDTH-1:0] pat, input int plen,
                            input logic [START_WIDTH-1:0] from);
      write_reg(CSR_PATTERN_BYTES, pat);
      write_reg(CSR_PATTERN_LENGTH, PAT_WIDTH'(plen));
      write_reg(CSR_SEARCH_START, PAT_WIDTH'(from));
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   // hold the stream until every expected result is out, then let the pipe settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (predictor.pending() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // one buffer, mostly built from pattern bytes, often with the pattern planted
   task automatic send_buffer(input logic [PAT_WIDTH-1:0] pat, input int plen);
      logic [7:0] data_q[$];
      int         size;
      int         spot;
      int         used;
      int         k;
      bit         biased;
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 16);
      used = (plen >= 1 && plen <= PAT_BYTES_MAX) ? plen : $urandom_range(1, PAT_BYTES_MAX);
      biased = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < size; i++) begin
         k = $urandom_range(0, used - 1);
         data_q.push_back(biased ? pat[8*k +: 8] : 8'($urandom));
      end
      if ($urandom_range(0, 2) != 0 && size >= used) begin
         spot = $urandom_range(0, size - used);
         for (int j = 0; j < used; j++) data_q[spot + j] = pat[8*j +: 8];
         // now and then a broken copy
         if ($urandom_range(0, 3) == 0) begin
            k = spot + $urandom_range(0, used - 1);
            data_q[k] = data_q[k] ^ 8'($urandom_range(1, 255));
         end
      end
      for (int i = 0; i < size; i++) push_byte(data_q[i], i == size - 1);
   endtask

   initial begin
      logic [PAT_WIDTH-1:0]   pat;
      logic [START_WIDTH-1:0] from;
      logic [7:0]             sym_a;
      logic [7:0]             sym_b;
      int                     plen;
      int                     directed_bytes;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset registers, one-byte zero pattern matching on the last byte
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b1);
      drain();
      // full-length pattern completed by the final byte
      configure(64'hFFEE_DDCC_BBAA_9988, 8, 0);
      for (int i = 0; i < 8; i++) push_byte(8'h88 + 8'(i * 8'h11), i == 7);
      drain();
      // zero length and oversize length never match
      configure(64'h0, 0, 0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b1);
      drain();
      configure({PAT_WIDTH{1'b1}}, 15, 0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b1);
      drain();
      // pattern longer than the buffer
      configure(64'h4443_4241, 4, 0);
      push_byte(8'h41, 1'b0);
      push_byte(8'h42, 1'b1);
      drain();
      // early hits ignored before search start, later bytes absorbed
      configure(64'h41, 1, 3);
      for (int i = 0; i < 5; i++) push_byte(8'h41, i == 4);
      drain();
      // search start at the top of the range
      configure(64'h41, 1, {START_WIDTH{1'b1}});
      push_byte(8'h41, 1'b0);
      push_byte(8'h41, 1'b1);
      drain();
      directed_bytes = byte_count;

      // random settings, a handful of buffers each
      while (byte_count - directed_bytes < RANDOM_BYTES) begin
         case ($urandom_range(0, 5))
            0, 1: pat = {$urandom, $urandom};
            2, 3: begin
               sym_a = 8'($urandom);
               sym_b = 8'($urandom);
               for (int i = 0; i < 8; i++) pat[8*i +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
            end
            4: pat = {PAT_WIDTH{1'b1}};
            default: pat = '0;
         endcase
         if ($urandom_range(0, 7) == 0)
            plen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(9, 15);
         else
            plen = $urandom_range(1, 8);
         case ($urandom_range(0, 9))
            6, 7: from = '0;
            8: from = {START_WIDTH{1'b1}};
            9: from = $urandom;
            default: from = $urandom_range(0, 12);
         endcase
         drain();
         configure(pat, plen, from);
         if (byte_count - directed_bytes >= RANDOM_BYTES - 100) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0: send_idle_pct = 0;
               1: send_idle_pct = 15;
               default: send_idle_pct = 40;
            endcase
            case ($urandom_range(0, 2))
               0: recv_idle_pct = 0;
               1: recv_idle_pct = 15;
               default: recv_idle_pct = 40;
            endcase
         end
         repeat ($urandom_range(2, 6)) send_buffer(pat, plen);
      end

      drain();
      $display("Scanned %0d bytes in %0d buffers under %0d register settings",
               byte_count, predictor.buffers, setting_count);
      $display("Reported %0d first matches and %0d misses", predictor.hits, predictor.misses);
      if (predictor.errors == 0 && predictor.pending() == 0) begin
         $display("** byte_pattern_first_match_core: PASSED **");
      end else begin
         $display("** byte_pattern_first_match_core: FAILED **");
      end
      $finish;
   end

endmodule
